// File: rtl/skyrp_pkg.sv
`timescale 1ns / 1ps

package skyrp_pkg;

	// Table and coordinate sizes.
	localparam int MAX_NODES  = 64;
	localparam int COORD_BITS = 13;
	localparam int IDX_W      = $clog2(MAX_NODES);
	localparam int CNT_W      = $clog2(MAX_NODES + 2);
	localparam int SUM_W      = COORD_BITS + 1;
	localparam int DATA_W     = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int REG_IDX_W  = 2;

	localparam logic [COORD_BITS-1:0] BIN_RESET = COORD_BITS'(4096);

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_BIN_WIDTH  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_BIN_HEIGHT = REG_IDX_W'(1);

	// Result status codes.
	localparam logic [1:0] ST_PLACED = 2'd0;
	localparam logic [1:0] ST_NOFIT  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// One skyline segment.
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] len;
	} seg_t;

	localparam int SEG_W = $bits(seg_t);

endpackage

// File: rtl/skyrp_seg_ram.sv
`timescale 1ns / 1ps

module skyrp_seg_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 39
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/skyline_rect_packer_unit.sv
`timescale 1ns / 1ps
// Operation: after acceptance, a fresh start first writes one segment spanning the bin
// width; then a search tries every segment as a start and walks the segments each trial
// spans, and a rebuild writes the new skyline into the other bank. Every segment access
// goes through the single read port of the segment memory. One transaction at a time;
// a new rectangle is accepted only while idle, and a finished result waits in the
// output register. Reset: asynchronous, active low; clears control state and segment count,
// and loads both bin registers with 4096.
module skyline_rect_packer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [skyrp_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [skyrp_pkg::COORD_BITS-1:0] cfg_wdata,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [skyrp_pkg::DATA_W-1:0]  s_tdata,  // rect_width, rect_height, zero fill
	input  logic [0:0]                    s_tuser,  // start_new
	// Result stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skyrp_pkg::DATA_W-1:0]  m_tdata,  // pos_x, pos_y, zero fill
	output logic [1:0]                    m_tuser   // status
);
	import skyrp_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_INIT  = 4'd1;
	localparam logic [3:0] S_ORD   = 4'd2;
	localparam logic [3:0] S_OWT   = 4'd3;
	localparam logic [3:0] S_IRD   = 4'd4;
	localparam logic [3:0] S_IWT   = 4'd5;
	localparam logic [3:0] S_RRD   = 4'd6;
	localparam logic [3:0] S_RWT   = 4'd7;
	localparam logic [3:0] S_FLUSH = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODES);

	logic [3:0]            state_q;
	logic                  bank_q;
	logic [CNT_W-1:0]      cnt_q, i_q, j_q, k_q, wcnt_q, bi_q;
	logic [COORD_BITS-1:0] bw_q, bh_q, w_q, h_q;
	logic [COORD_BITS-1:0] y_q, rem_q, xi_q, leni_q;
	logic                  found_q;
	logic [COORD_BITS-1:0] bx_q, by_q, bwid_q;
	logic [SUM_W-1:0]      btop_q;
	logic                  ins_q, trim_q, pvld_q;
	seg_t                  p_q;
	logic [1:0]            st_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic                  m_tvalid_q;
	logic [DATA_W-1:0]     m_tdata_q;
	logic [1:0]            m_tuser_q;

	logic                  wr_en;
	logic [IDX_W:0]        wr_addr, rd_addr;
	seg_t                  wr_data, rd_data;
	logic [SEG_W-1:0]      rd_raw;

	logic                  ent_vld;
	seg_t                  ent;
	logic                  mrg_wr;

	logic [COORD_BITS-1:0] in_w, in_h, ny, rem_nx;
	logic [SUM_W-1:0]      pe, sh, top_nx;
	logic                  s_acc, zero_rect;

	assign in_w  = s_tdata[COORD_BITS-1:0];
	assign in_h  = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign s_tready = (state_q == S_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign zero_rect = (w_q == '0) || (h_q == '0);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	skyrp_seg_ram #(.DEPTH(2 * MAX_NODES), .WIDTH(SEG_W)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_raw)
	);
	assign rd_data = seg_t'(rd_raw);

	// Search step arithmetic.
	assign ny     = (rd_data.y > y_q) ? rd_data.y : y_q;
	assign rem_nx = (rd_data.len >= rem_q) ? '0 : rem_q - rd_data.len;
	assign top_nx = {1'b0, ny} + {1'b0, h_q};

	// Trim arithmetic against the end of the new segment.
	assign pe = {1'b0, bx_q} + {1'b0, w_q};
	assign sh = pe - {1'b0, rd_data.x};

	// Read address of the active bank.
	always_comb begin
		case (state_q)
			S_ORD:   rd_addr = {bank_q, i_q[IDX_W-1:0]};
			S_IRD:   rd_addr = {bank_q, j_q[IDX_W-1:0]};
			default: rd_addr = {bank_q, k_q[IDX_W-1:0]};
		endcase
	end

	// Entry fed to the merge stage during rebuild.
	always_comb begin
		ent_vld = 1'b0;
		ent     = rd_data;
		if (state_q == S_RRD && !ins_q && k_q == bi_q) begin
			ent_vld = 1'b1;
			ent.x   = bx_q;
			ent.y   = btop_q[COORD_BITS-1:0];
			ent.len = w_q;
		end else if (state_q == S_RWT) begin
			if (trim_q && {1'b0, rd_data.x} < pe) begin
				if ({1'b0, rd_data.len} > sh) begin
					ent_vld = 1'b1;
					ent.x   = pe[COORD_BITS-1:0];
					ent.len = rd_data.len - sh[COORD_BITS-1:0];
				end
			end else begin
				ent_vld = 1'b1;
			end
		end
	end

	assign mrg_wr = ent_vld && pvld_q && (p_q.y != ent.y);

	// Write port: fresh skyline in the active bank, or rebuilt entries in the other bank.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {!bank_q, wcnt_q[IDX_W-1:0]};
		wr_data = p_q;
		if (state_q == S_INIT) begin
			wr_en   = 1'b1;
			wr_addr = {bank_q, IDX_W'(0)};
			wr_data = '{x: '0, y: '0, len: bw_q};
		end else if ((mrg_wr || (state_q == S_FLUSH && pvld_q)) && wcnt_q < CNT_MAX) begin
			wr_en = 1'b1;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= BIN_RESET;
			bh_q <= BIN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_BIN_WIDTH) begin
				bw_q <= cfg_wdata;
			end else if (cfg_index == REG_BIN_HEIGHT) begin
				bh_q <= cfg_wdata;
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			bank_q     <= 1'b0;
			cnt_q      <= '0;
			found_q    <= 1'b0;
			ins_q      <= 1'b0;
			trim_q     <= 1'b0;
			pvld_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= ST_PLACED;
			st_q       <= ST_PLACED;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			// Merge stage of the rebuild.
			if (ent_vld) begin
				if (!pvld_q || p_q.y != ent.y) begin
					p_q    <= ent;
					pvld_q <= 1'b1;
				end else begin
					p_q.len <= p_q.len + ent.len;
				end
				if (mrg_wr) begin
					wcnt_q <= wcnt_q + 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						w_q <= in_w;
						h_q <= in_h;
						i_q <= '0;
						found_q <= 1'b0;
						if (s_tuser[0] || cnt_q == '0) begin
							state_q <= S_INIT;
						end else if (in_w == '0 || in_h == '0) begin
							st_q <= ST_NOFIT; px_q <= '0; py_q <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_ORD;
						end
					end
				end
				S_INIT: begin
					cnt_q <= CNT_W'(1);
					if (zero_rect) begin
						st_q <= ST_NOFIT; px_q <= '0; py_q <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ORD;
					end
				end
				S_ORD: begin
					if (i_q >= cnt_q) begin
						if (found_q) begin
							k_q <= '0; wcnt_q <= '0;
							ins_q <= 1'b0; trim_q <= 1'b0; pvld_q <= 1'b0;
							state_q <= S_RRD;
						end else begin
							st_q <= ST_NOFIT; px_q <= '0; py_q <= '0;
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_OWT;
					end
				end
				S_OWT: begin
					if ({1'b0, rd_data.x} + {1'b0, w_q} > {1'b0, bw_q}) begin
						i_q <= i_q + 1'b1;
						state_q <= S_ORD;
					end else begin
						y_q <= rd_data.y; rem_q <= w_q; j_q <= i_q;
						xi_q <= rd_data.x; leni_q <= rd_data.len;
						state_q <= S_IRD;
					end
				end
				S_IRD: begin
					if (j_q >= cnt_q) begin
						i_q <= i_q + 1'b1;
						state_q <= S_ORD;
					end else begin
						state_q <= S_IWT;
					end
				end
				S_IWT: begin
					if (top_nx > {1'b0, bh_q}) begin
						i_q <= i_q + 1'b1;
						state_q <= S_ORD;
					end else if (rem_nx == '0) begin
						if (!found_q || top_nx < btop_q ||
						    (top_nx == btop_q && leni_q < bwid_q)) begin
							found_q <= 1'b1;
							bi_q <= i_q; bx_q <= xi_q; by_q <= ny;
							btop_q <= top_nx; bwid_q <= leni_q;
						end
						i_q <= i_q + 1'b1;
						state_q <= S_ORD;
					end else begin
						y_q <= ny; rem_q <= rem_nx; j_q <= j_q + 1'b1;
						state_q <= S_IRD;
					end
				end
				S_RRD: begin
					if (!ins_q && k_q == bi_q) begin
						ins_q <= 1'b1;
						trim_q <= 1'b1;
					end else if (k_q >= cnt_q) begin
						state_q <= S_FLUSH;
					end else begin
						state_q <= S_RWT;
					end
				end
				S_RWT: begin
					k_q <= k_q + 1'b1;
					if (!(trim_q && {1'b0, rd_data.x} < pe && {1'b0, rd_data.len} <= sh)) begin
						trim_q <= 1'b0;
					end
					state_q <= S_RRD;
				end
				S_FLUSH: begin
					if (wcnt_q + 1'b1 > CNT_MAX) begin
						st_q <= ST_FULL; px_q <= '0; py_q <= '0;
					end else begin
						bank_q <= !bank_q;
						cnt_q  <= wcnt_q + 1'b1;
						st_q <= ST_PLACED; px_q <= bx_q; py_q <= by_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= DATA_W'({py_q, px_q});
						m_tuser_q  <= st_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX) else $error("segment count above table size");
	a_rebuild_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q != S_INIT) |-> (wr_addr[IDX_W] != bank_q))
		else $error("rebuild wrote into the active bank");
	a_unplaced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_PLACED) |-> (m_tdata == '0))
		else $error("position nonzero on an unplaced result");
	a_best_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RRD) |-> (btop_q <= {1'b0, bh_q}))
		else $error("chosen position exceeds bin height");
`endif

endmodule
